// ----- rtl/core/slfc_pkg.sv -----
// Shared constants for the silence/length frame codec.
// No dependencies.
package slfc_pkg;

	localparam int BUF_DEPTH = 2048;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

	localparam int BYTE_W    = 8;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 4;
	localparam int COUNT_W   = 12;
	localparam int SIL_W     = 4;
	localparam int TMO_W     = 14;
	localparam int FRAME_W   = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_SLOT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEND  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RECV  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

	localparam logic [SIL_W-1:0] SILENCE_RST = 4'd3;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 14'd10000;

	localparam logic [BYTE_W-1:0] LEN_FLAG = 8'h80;
	localparam logic [BYTE_W-1:0] LEN_MASK = 8'h7f;

endpackage

// ----- rtl/core/slfc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds while read enable is low.
module slfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/silence_length_frame_codec_unit.sv -----
// Silence/length framing engine with an internal byte FIFO.
// Depends on slfc_pkg and slfc_ram.
// Result word is registered in the cycle after the word is accepted; one word
// per cycle unless out_ready stalls, set by the single buffer access per word
// (write on push, read on pop). Reset clears phase, counters, pointers and fill
// count; buffer contents stay undefined and need no clearing pass.
module silence_length_frame_codec_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [slfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slfc_pkg::TMO_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [slfc_pkg::MODE_W-1:0]        mode,
	input  logic [slfc_pkg::BYTE_W-1:0]        line_in,
	input  logic [slfc_pkg::BYTE_W-1:0]        data_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [slfc_pkg::BYTE_W-1:0]        line_out,
	output logic                               active,
	output logic [slfc_pkg::STATUS_W-1:0]      status,
	output logic [slfc_pkg::BYTE_W-1:0]        data_out,
	output logic                               data_valid,
	output logic [slfc_pkg::COUNT_W-1:0]       buffer_count
);
	import slfc_pkg::*;

	typedef enum logic [STATUS_W-1:0] {
		PH_IDLE        = 4'd0,
		PH_S_SIL       = 4'd1,
		PH_S_LMSB      = 4'd2,
		PH_S_LLSB      = 4'd3,
		PH_S_BODY      = 4'd4,
		PH_R_SIL       = 4'd5,
		PH_R_LMSB      = 4'd6,
		PH_R_LLSB      = 4'd7,
		PH_R_BODY      = 4'd8,
		PH_S_OK        = 4'd9,
		PH_R_OK        = 4'd10,
		PH_ERR_LINE    = 4'd11,
		PH_ERR_TIMEOUT = 4'd12
	} phase_t;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUF_DEPTH);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUF_DEPTH - 1);

	phase_t              phase_q, phase_d;
	logic [FRAME_W-1:0]  frame_q, frame_d;
	logic [FRAME_W-1:0]  target_q, target_d;
	logic [PTR_W-1:0]    rptr_q, rptr_d;
	logic [PTR_W-1:0]    wptr_q, wptr_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [SIL_W-1:0]    silence_q;
	logic [TMO_W-1:0]    timeout_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   line_q;
	logic                active_q;
	logic [STATUS_W-1:0] status_q;
	logic                dvalid_q;
	logic [COUNT_W-1:0]  count_q;
	logic                line_mem_q;
	logic                data_mem_q;

	logic                accept;
	logic                push, pop;
	logic [BYTE_W-1:0]   push_byte;
	logic [BYTE_W-1:0]   line_d;
	logic                active_d;
	logic                dvalid_d;
	logic                line_mem_d;
	logic [FILL_W-1:0]   fill_push;
	logic [15:0]         fill_wide;
	logic [BYTE_W-1:0]   rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign fill_wide = 16'(fill_q);
	assign fill_push = (fill_q == FILL_FULL) ? fill_q : fill_q + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		frame_d    = frame_q;
		target_d   = target_q;
		push       = 1'b0;
		pop        = 1'b0;
		push_byte  = data_in;
		line_d     = '0;
		active_d   = 1'b0;
		dvalid_d   = 1'b0;
		line_mem_d = 1'b0;
		case (mode)
			MODE_SLOT: begin
				case (phase_q)
					PH_S_SIL: begin
						active_d = 1'b1;
						if (FRAME_W'(silence_q) < frame_q) begin
							frame_d = '0;
							phase_d = PH_S_LMSB;
						end else begin
							frame_d = frame_q + 1'b1;
						end
					end
					PH_S_LMSB: begin
						line_d   = fill_wide[15:8] | LEN_FLAG;
						active_d = 1'b1;
						phase_d  = PH_S_LLSB;
					end
					PH_S_LLSB: begin
						line_d   = fill_wide[7:0];
						active_d = 1'b1;
						phase_d  = PH_S_BODY;
					end
					PH_S_BODY: begin
						if (fill_q == '0) begin
							phase_d = PH_S_OK;
						end else begin
							pop        = 1'b1;
							line_mem_d = 1'b1;
							active_d   = 1'b1;
						end
					end
					PH_R_SIL: begin
						if (line_in != '0) begin
							phase_d = PH_ERR_LINE;
						end else begin
							active_d = 1'b1;
							if (FRAME_W'(silence_q) < frame_q) begin
								frame_d = '0;
								phase_d = PH_R_LMSB;
							end else begin
								frame_d = frame_q + 1'b1;
							end
						end
					end
					PH_R_LMSB: begin
						if (line_in != '0) begin
							target_d = {line_in[6:0] & LEN_MASK[6:0], 8'h00};
							phase_d  = PH_R_LLSB;
							active_d = 1'b1;
						end else begin
							frame_d = frame_q + 1'b1;
							if (FRAME_W'(timeout_q) < frame_q) begin
								phase_d = PH_ERR_TIMEOUT;
							end else begin
								active_d = 1'b1;
							end
						end
					end
					PH_R_LLSB: begin
						target_d = target_q | FRAME_W'(line_in);
						phase_d  = PH_R_BODY;
						active_d = 1'b1;
					end
					PH_R_BODY: begin
						push      = 1'b1;
						push_byte = line_in;
						if (FRAME_W'(fill_push) >= target_q) begin
							phase_d = PH_R_OK;
						end else begin
							active_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_PUSH: begin
				push = 1'b1;
			end
			MODE_POP: begin
				if (fill_q != '0) begin
					pop      = 1'b1;
					dvalid_d = 1'b1;
				end
			end
			MODE_SEND: begin
				frame_d = '0;
				phase_d = PH_S_SIL;
			end
			MODE_RECV: begin
				frame_d = '0;
				phase_d = PH_R_SIL;
			end
			default: begin
			end
		endcase
	end

	// full buffer drops the byte
	logic do_write, do_read;
	assign do_write = accept && push && (fill_q != FILL_FULL);
	assign do_read  = accept && pop;

	always_comb begin
		wptr_d = wptr_q;
		rptr_d = rptr_q;
		fill_d = fill_q;
		if (do_write) begin
			wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			fill_d = fill_q + 1'b1;
		end
		if (do_read) begin
			rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			fill_d = fill_q - 1'b1;
		end
	end

	slfc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (do_write),
		.waddr(wptr_q),
		.wdata(push_byte),
		.re   (do_read),
		.raddr(rptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q <= SILENCE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SILENCE: silence_q <= cfg_data[SIL_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			frame_q     <= '0;
			target_q    <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				frame_q  <= frame_d;
				target_q <= target_d;
				rptr_q   <= rptr_d;
				wptr_q   <= wptr_d;
				fill_q   <= fill_d;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q     <= line_d;
			active_q   <= active_d;
			status_q   <= STATUS_W'(phase_d);
			dvalid_q   <= dvalid_d;
			count_q    <= COUNT_W'(fill_d);
			line_mem_q <= line_mem_d;
			data_mem_q <= dvalid_d;
		end
	end

	// popped byte comes straight from the RAM read register
	assign out_valid    = out_valid_q;
	assign line_out     = line_mem_q ? rdata : line_q;
	assign active       = active_q;
	assign status       = status_q;
	assign data_out     = data_mem_q ? rdata : '0;
	assign data_valid   = dvalid_q;
	assign buffer_count = count_q;

endmodule
